>>> design/pfi_pkg.sv
// ---------------------------------------------------------------------------
// pfi_pkg
// Shared types and constants for the particle force integrator.
// ---------------------------------------------------------------------------
`default_nettype none

package pfi_pkg;

	localparam logic [3:0] ACT_LOAD    = 4'd0;
	localparam logic [3:0] ACT_CLEAR   = 4'd1;
	localparam logic [3:0] ACT_MASS    = 4'd2;
	localparam logic [3:0] ACT_RAW     = 4'd3;
	localparam logic [3:0] ACT_REPEL   = 4'd4;
	localparam logic [3:0] ACT_ATTRACT = 4'd5;
	localparam logic [3:0] ACT_UPDATE  = 4'd6;
	localparam logic [3:0] ACT_BOUNCE  = 4'd7;
	localparam logic [3:0] ACT_WRAP    = 4'd8;

	localparam logic [1:0] REG_FRICTION = 2'd0;
	localparam logic [1:0] REG_INV_MASS = 2'd1;
	localparam logic [1:0] REG_PINNED   = 2'd2;
	localparam logic [1:0] REG_WALL_MAX = 2'd3;

	localparam logic [16:0] FRICTION_RST = 17'd655;
	localparam logic [24:0] INV_MASS_RST = 25'd65536;
	localparam logic [30:0] WALL_MAX_RST = 31'd131072000;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISP,
		ST_MUL,
		ST_MACC,
		ST_UPD_V,
		ST_UPD_P,
		ST_R_RNG,
		ST_R_SQM,
		ST_R_SQA,
		ST_R_RRM,
		ST_R_CHK,
		ST_R_SQRT,
		ST_R_PCT,
		ST_R_PDIV,
		ST_R_TM,
		ST_R_TDL,
		ST_R_TDIV,
		ST_R_TPM,
		ST_R_TACC,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

>>> design/particle_force_integrator.sv
// ---------------------------------------------------------------------------
// particle_force_integrator
// One 3-D particle in Q15.16 that executes one command word at a time.
// ---------------------------------------------------------------------------
// Channel  Dir  Handshake                 Contents
// s_*      in   tvalid/tready             command word
// m_*      out  tvalid/tready             particle state word
// apb      in   psel/penable/pready       four configuration registers
//
// Load, clear, raw force, bounce, wrap and unknown commands finish right
// after dispatch; force-over-mass and update use the multiplier once per axis,
// and an update that is not pinned then adds velocity and position. Radial
// commands run the shared 32-step divider (four passes) and the 32-step square
// root loop; one out of reach ends before the square root.
// Reset clears the particle state and loads the register defaults.
// A result waits in an output register; the next word is not taken until
// the sequencer returns to idle.
`default_nettype none

module particle_force_integrator (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output      logic         s_tready,
	// action, arg_x, arg_y, arg_z, arg_vx, arg_vy, arg_vz, reach, strength
	input  wire logic [263:0] s_tdata,
	output      logic         m_tvalid,
	input  wire logic         m_tready,
	// pos_x..z, vel_x..z, frc_x..z, collided
	output      logic [295:0] m_tdata,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output      logic [31:0]  prdata,
	output      logic         pready
);
	import pfi_pkg::*;

	function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
		if (v > 52'sd2147483647) return 32'sh7fffffff;
		if (v < -52'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	state_t state_q, state_d;

	logic [16:0] friction_q;
	logic [24:0] inv_mass_q;
	logic        pinned_q;
	logic [30:0] wall_max_q;

	logic signed [31:0] pos_q [3];
	logic signed [31:0] vel_q [3];
	logic signed [31:0] frc_q [3];
	logic               col_q;

	logic [3:0]         act_q;
	logic signed [31:0] a_q [3];
	logic signed [31:0] v_q [3];
	logic [30:0]        reach_q;
	logic signed [31:0] strength_q;

	logic signed [32:0] d_q [3];
	logic [1:0]         ax_q;
	logic [4:0]         cnt_q;
	logic signed [65:0] prod_q;
	logic [63:0]        sum_q;
	logic [63:0]        sq_n_q, sq_res_q;
	logic [30:0]        div_rem_q, div_den_q;
	logic [31:0]        div_lo_q, div_quo_q;
	logic [16:0]        pct_q;
	logic               t_neg_q;
	logic signed [32:0] t_q;

	logic         out_valid_q;
	logic [288:0] out_data_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] rnd_w;
	logic signed [51:0] term;
	logic [31:0]        div_sh;
	logic               div_ge;
	logic [31:0]        quo_next;
	logic [63:0]        sq_bit, sq_try;
	logic [65:0]        prod_abs;
	logic               out_range;
	logic               fin_go;
	logic signed [32:0] wmax_s;
	logic [30:0]        pct_num;
	logic [2:0]         bnc_hit;

	assign pready   = 1'b1;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_data_q};
	assign fin_go   = !out_valid_q || m_tready;
	assign wmax_s   = {2'b0, wall_max_q};

	always_comb begin
		unique case (paddr[3:2])
			REG_FRICTION: prdata = {15'b0, friction_q};
			REG_INV_MASS: prdata = {7'b0, inv_mass_q};
			REG_PINNED:   prdata = {31'b0, pinned_q};
			REG_WALL_MAX: prdata = {1'b0, wall_max_q};
			default:      prdata = '0;
		endcase
	end

	// Shared datapath helpers.
	assign rnd_w    = (prod_q + 66'sd32768) >>> 16;
	assign term     = rnd_w[51:0];
	assign div_sh   = {div_rem_q, div_lo_q[31]};
	assign div_ge   = div_sh >= {1'b0, div_den_q};
	assign quo_next = {div_quo_q[30:0], div_ge};
	assign sq_bit   = 64'h4000_0000_0000_0000 >> {cnt_q, 1'b0};
	assign sq_try   = sq_res_q + sq_bit;
	assign prod_abs = prod_q[65] ? 66'(-prod_q) : prod_q;
	assign pct_num  = reach_q - sq_res_q[30:0];

	always_comb begin
		out_range = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (d_q[i] > $signed({2'b0, reach_q}) || d_q[i] < -$signed({2'b0, reach_q}))
				out_range = 1'b1;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++)
			bnc_hit[i] = ($signed({pos_q[i][31], pos_q[i]}) > wmax_s) || (pos_q[i] < 0);
	end

	// Operand select for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MUL: begin
				if (act_q == ACT_MASS) begin
					mul_a = {a_q[ax_q][31], a_q[ax_q]};
					mul_b = {8'b0, inv_mass_q};
				end else begin
					mul_a = {vel_q[ax_q][31], vel_q[ax_q]};
					mul_b = {16'b0, friction_q};
				end
			end
			ST_R_SQM: begin
				mul_a = d_q[ax_q];
				mul_b = d_q[ax_q];
			end
			ST_R_RRM: begin
				mul_a = {2'b0, reach_q};
				mul_b = {2'b0, reach_q};
			end
			ST_R_TM: begin
				mul_a = d_q[ax_q];
				mul_b = {strength_q[31], strength_q};
			end
			ST_R_TPM: begin
				mul_a = t_q;
				mul_b = {16'b0, pct_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_DISP;
			ST_DISP: begin
				case (act_q)
					ACT_MASS, ACT_UPDATE:   state_d = ST_MUL;
					ACT_REPEL, ACT_ATTRACT: state_d = ST_R_RNG;
					default:                state_d = ST_FIN;
				endcase
			end
			ST_MUL:  state_d = ST_MACC;
			ST_MACC: begin
				if (ax_q != 2'd2) state_d = ST_MUL;
				else if (act_q == ACT_UPDATE && !pinned_q) state_d = ST_UPD_V;
				else state_d = ST_FIN;
			end
			ST_UPD_V: state_d = ST_UPD_P;
			ST_UPD_P: state_d = ST_FIN;
			ST_R_RNG: state_d = (reach_q == '0 || out_range) ? ST_FIN : ST_R_SQM;
			ST_R_SQM: state_d = ST_R_SQA;
			ST_R_SQA: state_d = (ax_q == 2'd2) ? ST_R_RRM : ST_R_SQM;
			ST_R_RRM: state_d = ST_R_CHK;
			ST_R_CHK: state_d = (sum_q == '0 || sum_q > prod_q[63:0]) ? ST_FIN : ST_R_SQRT;
			ST_R_SQRT: if (cnt_q == 5'd31) state_d = ST_R_PCT;
			ST_R_PCT:  state_d = ST_R_PDIV;
			ST_R_PDIV: if (cnt_q == 5'd31) state_d = ST_R_TM;
			ST_R_TM:   state_d = ST_R_TDL;
			ST_R_TDL:  state_d = ST_R_TDIV;
			ST_R_TDIV: if (cnt_q == 5'd31) state_d = ST_R_TPM;
			ST_R_TPM:  state_d = ST_R_TACC;
			ST_R_TACC: state_d = (ax_q == 2'd2) ? ST_FIN : ST_R_TM;
			ST_FIN:    if (fin_go) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Control and particle state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			friction_q  <= FRICTION_RST;
			inv_mass_q  <= INV_MASS_RST;
			pinned_q    <= 1'b0;
			wall_max_q  <= WALL_MAX_RST;
			out_valid_q <= 1'b0;
			col_q       <= 1'b0;
			ax_q        <= '0;
			cnt_q       <= '0;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
				frc_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite) begin
				unique case (paddr[3:2])
					REG_FRICTION: friction_q <= pwdata[16:0];
					REG_INV_MASS: inv_mass_q <= pwdata[24:0];
					REG_PINNED:   pinned_q   <= pwdata[0];
					REG_WALL_MAX: wall_max_q <= pwdata[30:0];
					default:      pinned_q   <= pinned_q;
				endcase
			end
			if (state_q == ST_FIN && fin_go) out_valid_q <= 1'b1;
			else if (m_tvalid && m_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					col_q <= 1'b0;
					ax_q  <= '0;
					cnt_q <= '0;
				end
				ST_DISP: begin
					case (act_q)
						ACT_LOAD: begin
							for (int i = 0; i < 3; i++) begin
								pos_q[i] <= a_q[i];
								vel_q[i] <= v_q[i];
							end
						end
						ACT_CLEAR: for (int i = 0; i < 3; i++) frc_q[i] <= '0;
						ACT_RAW: begin
							for (int i = 0; i < 3; i++)
								frc_q[i] <= sat32(52'(frc_q[i]) + 52'(a_q[i]));
						end
						ACT_BOUNCE: begin
							for (int i = 0; i < 3; i++) begin
								if (bnc_hit[i]) begin
									pos_q[i] <= (pos_q[i] < 0) ? 32'sd0 : {1'b0, wall_max_q};
									vel_q[i] <= sat32(-52'(vel_q[i]));
								end
							end
							col_q <= |bnc_hit;
						end
						ACT_WRAP: begin
							for (int i = 0; i < 3; i++) begin
								if (pos_q[i] < 0) pos_q[i] <= {1'b0, wall_max_q};
								else if ($signed({pos_q[i][31], pos_q[i]}) > wmax_s)
									pos_q[i] <= '0;
							end
						end
						default: col_q <= 1'b0;
					endcase
				end
				ST_MACC: begin
					if (act_q == ACT_MASS) frc_q[ax_q] <= sat32(52'(frc_q[ax_q]) + term);
					else frc_q[ax_q] <= sat32(52'(frc_q[ax_q]) - term);
					ax_q <= ax_q + 2'd1;
				end
				ST_UPD_V: begin
					for (int i = 0; i < 3; i++)
						vel_q[i] <= sat32(52'(vel_q[i]) + 52'(frc_q[i]));
				end
				ST_UPD_P: begin
					for (int i = 0; i < 3; i++)
						pos_q[i] <= sat32(52'(pos_q[i]) + 52'(vel_q[i]));
				end
				ST_R_RNG:  ax_q <= '0;
				ST_R_SQA:  ax_q <= ax_q + 2'd1;
				ST_R_CHK:  cnt_q <= '0;
				ST_R_SQRT: cnt_q <= cnt_q + 5'd1;
				ST_R_PCT: begin
					cnt_q <= '0;
					ax_q  <= '0;
				end
				ST_R_PDIV: cnt_q <= cnt_q + 5'd1;
				ST_R_TDL:  cnt_q <= '0;
				ST_R_TDIV: cnt_q <= cnt_q + 5'd1;
				ST_R_TACC: begin
					if (act_q == ACT_ATTRACT) frc_q[ax_q] <= sat32(52'(frc_q[ax_q]) - term);
					else frc_q[ax_q] <= sat32(52'(frc_q[ax_q]) + term);
					ax_q <= ax_q + 2'd1;
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Payload and arithmetic working registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (state_q == ST_IDLE && s_tvalid) begin
			act_q      <= s_tdata[3:0];
			a_q[0]     <= s_tdata[35:4];
			a_q[1]     <= s_tdata[67:36];
			a_q[2]     <= s_tdata[99:68];
			v_q[0]     <= s_tdata[131:100];
			v_q[1]     <= s_tdata[163:132];
			v_q[2]     <= s_tdata[195:164];
			reach_q    <= s_tdata[226:196];
			strength_q <= s_tdata[258:227];
		end
		if (state_q == ST_DISP) begin
			for (int i = 0; i < 3; i++)
				d_q[i] <= 33'(pos_q[i]) - 33'(a_q[i]);
			sum_q <= '0;
		end
		if (state_q == ST_R_SQA) sum_q <= sum_q + prod_q[63:0];
		if (state_q == ST_R_CHK) begin
			sq_n_q   <= sum_q;
			sq_res_q <= '0;
		end
		if (state_q == ST_R_SQRT) begin
			if (sq_n_q >= sq_try) begin
				sq_n_q   <= sq_n_q - sq_try;
				sq_res_q <= (sq_res_q >> 1) + sq_bit;
			end else begin
				sq_res_q <= sq_res_q >> 1;
			end
		end
		if (state_q == ST_R_PCT) begin
			div_den_q <= reach_q;
			div_rem_q <= {16'b0, pct_num[30:16]};
			div_lo_q  <= {pct_num[15:0], 16'b0};
			div_quo_q <= '0;
		end
		if (state_q == ST_R_TDL) begin
			div_den_q <= sq_res_q[30:0];
			div_rem_q <= prod_abs[62:32];
			div_lo_q  <= prod_abs[31:0];
			div_quo_q <= '0;
			t_neg_q   <= prod_q[65];
		end
		if (state_q == ST_R_PDIV || state_q == ST_R_TDIV) begin
			div_rem_q <= div_ge ? 31'(div_sh - {1'b0, div_den_q}) : div_sh[30:0];
			div_lo_q  <= div_lo_q << 1;
			div_quo_q <= quo_next;
			if (cnt_q == 5'd31) begin
				if (state_q == ST_R_PDIV) pct_q <= quo_next[16:0];
				else t_q <= t_neg_q ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
			end
		end
		if (state_q == ST_FIN && fin_go) begin
			out_data_q <= {col_q, frc_q[2], frc_q[1], frc_q[0],
				vel_q[2], vel_q[1], vel_q[0], pos_q[2], pos_q[1], pos_q[0]};
		end
	end

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q != ST_IDLE))
		else $error("sequencer stayed idle after taking a word");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_R_PDIV || state_q == ST_R_TDIV) |-> (div_rem_q < div_den_q))
		else $error("divider remainder not below divisor");

	a_col: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q && state_q != ST_IDLE) |-> (act_q == ACT_BOUNCE))
		else $error("collision flag set outside a bounce");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking regression for the particle force integrator.
// Command words go in on the slave stream and each one is predicted by a
// behavioral copy of the particle kept here. Every particle state word on
// the master stream is compared field by field with the oldest prediction.
// Directed commands come first, then randomized command streams under
// several register settings, with random idling on both streams and
// phases of long output back-pressure and full drains.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pfi_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam logic [3:0] ACT_UNKNOWN = 4'd15;

	typedef struct {
		logic [3:0] action;
		int ax, ay, az, vx, vy, vz;
		logic [30:0] reach;
		int strength;
	} cmd_t;

	typedef struct {
		int p[3];
		int v[3];
		int f[3];
		bit collided;
	} particle_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// action, arg_x, arg_y, arg_z, arg_vx, arg_vy, arg_vz, reach, strength
	logic [263:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// pos_x..z, vel_x..z, frc_x..z, collided
	logic [295:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	particle_force_integrator dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor state: registers and particle.
	logic [16:0] friction_gain;
	logic [24:0] inv_mass;
	logic pinned;
	logic [30:0] wall_max;
	int pos[3], vel[3], frc[3];

	particle_t state_q[$];
	int errors = 0;
	int cycles = 0;
	int hold_req = 0;
	bit rx_quiet = 0;

	function automatic int sat32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return int'(v);
	endfunction

	function automatic longint round16(longint p);
		return (p + 32768) >>> 16;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic void apply_radial(cmd_t c, bit attract);
		longint d[3];
		longint cen[3];
		longint r;
		longint unsigned sum;
		longint unsigned len;
		longint pct, t, term;
		r = longint'(c.reach);
		cen[0] = c.ax; cen[1] = c.ay; cen[2] = c.az;
		if (r == 0) return;
		for (int i = 0; i < 3; i++) begin
			d[i] = longint'(pos[i]) - cen[i];
			if (d[i] > r || d[i] < -r) return;
		end
		sum = 0;
		for (int i = 0; i < 3; i++) sum += longint'(d[i] * d[i]);
		if (sum == 0 || sum > longint'(r * r)) return;
		len = int_sqrt(sum);
		pct = longint'(((longint'(r) - longint'(len)) << 16) / r);
		for (int i = 0; i < 3; i++) begin
			t = (d[i] * longint'(c.strength)) / longint'(len);
			term = round16(t * pct);
			frc[i] = sat32(attract ? longint'(frc[i]) - term : longint'(frc[i]) + term);
		end
	endfunction

	function automatic particle_t step_particle(cmd_t c);
		particle_t res;
		int a[3];
		longint wm;
		bit hit;
		a[0] = c.ax; a[1] = c.ay; a[2] = c.az;
		wm = longint'(wall_max);
		res.collided = 0;
		case (c.action)
			ACT_LOAD: begin
				pos = a;
				vel[0] = c.vx; vel[1] = c.vy; vel[2] = c.vz;
			end
			ACT_CLEAR: frc = '{0, 0, 0};
			ACT_MASS: for (int i = 0; i < 3; i++)
				frc[i] = sat32(longint'(frc[i]) + round16(longint'(a[i]) * longint'(inv_mass)));
			ACT_RAW: for (int i = 0; i < 3; i++)
				frc[i] = sat32(longint'(frc[i]) + longint'(a[i]));
			ACT_REPEL: apply_radial(c, 0);
			ACT_ATTRACT: apply_radial(c, 1);
			ACT_UPDATE: begin
				for (int i = 0; i < 3; i++)
					frc[i] = sat32(longint'(frc[i])
						- round16(longint'(vel[i]) * longint'(friction_gain)));
				if (!pinned) begin
					for (int i = 0; i < 3; i++) begin
						vel[i] = sat32(longint'(vel[i]) + longint'(frc[i]));
						pos[i] = sat32(longint'(pos[i]) + longint'(vel[i]));
					end
				end
			end
			ACT_BOUNCE: for (int i = 0; i < 3; i++) begin
				hit = 0;
				if (longint'(pos[i]) > wm) begin
					pos[i] = int'(wm);
					hit = 1;
				end else if (pos[i] < 0) begin
					pos[i] = 0;
					hit = 1;
				end
				if (hit) begin
					vel[i] = sat32(-longint'(vel[i]));
					res.collided = 1;
				end
			end
			ACT_WRAP: for (int i = 0; i < 3; i++) begin
				if (pos[i] < 0) pos[i] = int'(wm);
				if (longint'(pos[i]) > wm) pos[i] = 0;
			end
			default: ;
		endcase
		res.p = pos;
		res.v = vel;
		res.f = frc;
		return res;
	endfunction

	function automatic int send_gap();
		int r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	task automatic send_cmd(cmd_t c, bit no_gap = 0);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, c.strength, c.reach, c.vz, c.vy, c.vx, c.az, c.ay, c.ax, c.action};
		do @(posedge clk); while (!s_tready);
		state_q.push_back(step_particle(c));
		gap = no_gap ? 0 : send_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (state_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_FRICTION: friction_gain = value[16:0];
			REG_INV_MASS: inv_mass = value[24:0];
			REG_PINNED:   pinned = value[0];
			REG_WALL_MAX: wall_max = value[30:0];
		endcase
		@(posedge clk);
	endtask

	task automatic set_regs(logic [16:0] fg, logic [24:0] im, bit pn, logic [30:0] wm);
		write_reg(REG_FRICTION, 32'(fg));
		write_reg(REG_INV_MASS, 32'(im));
		write_reg(REG_PINNED, 32'(pn));
		write_reg(REG_WALL_MAX, 32'(wm));
	endtask

	function automatic cmd_t make_cmd(logic [3:0] act, int x, int y, int z,
		int vx = 0, int vy = 0, int vz = 0, logic [30:0] reach = 0, int strength = 0);
		cmd_t c;
		c.action = act;
		c.ax = x; c.ay = y; c.az = z;
		c.vx = vx; c.vy = vy; c.vz = vz;
		c.reach = reach;
		c.strength = strength;
		return c;
	endfunction

	function automatic int rand_value();
		int r = $urandom_range(0, 9);
		if (r < 5) return $urandom_range(0, 32'h01ffffff) - 32'sh01000000;
		if (r < 8) return $urandom;
		if (r == 8) return 32'sh7fffffff;
		return 32'sh80000000;
	endfunction

	function automatic int rand_pos();
		if ($urandom_range(0, 9) < 8) return $urandom_range(0, wall_max);
		return rand_value();
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int r = $urandom_range(0, 99);
		int off;
		c = make_cmd(ACT_CLEAR, rand_value(), rand_value(), rand_value(),
			rand_value(), rand_value(), rand_value(), 31'($urandom), $urandom);
		if (r < 8) begin
			c.action = ACT_LOAD;
			c.ax = rand_pos(); c.ay = rand_pos(); c.az = rand_pos();
		end else if (r < 12) c.action = ACT_CLEAR;
		else if (r < 20) c.action = ACT_MASS;
		else if (r < 28) c.action = ACT_RAW;
		else if (r < 56) begin
			c.action = $urandom_range(0, 1) ? ACT_REPEL : ACT_ATTRACT;
			if ($urandom_range(0, 9) < 8) begin
				off = $urandom_range(1, 24);
				c.reach = 31'($urandom_range(1, 32'h7fffffff) >> $urandom_range(0, 30));
				c.ax = sat32(longint'(pos[0]) - (longint'($urandom) >> (8 + off)) + 2048);
				c.ay = sat32(longint'(pos[1]) + (longint'($urandom) >> (8 + off)) - 2048);
				c.az = sat32(longint'(pos[2]) - (longint'($urandom) >> (8 + off)));
				if ($urandom_range(0, 1)) c.strength = c.strength >>> $urandom_range(0, 31);
			end
		end else if (r < 78) c.action = ACT_UPDATE;
		else if (r < 88) c.action = ACT_BOUNCE;
		else if (r < 96) c.action = ACT_WRAP;
		else c.action = 4'($urandom_range(9, 15));
		return c;
	endfunction

	task automatic test_directed();
		send_cmd(make_cmd(ACT_LOAD, 32'sh7fffffff, 32'sh80000000, 0,
			32'sh80000000, 32'sh7fffffff, -1));
		send_cmd(make_cmd(ACT_RAW, 32'sh7fffffff, 32'sh80000000, 65536));
		send_cmd(make_cmd(ACT_RAW, 32'sh7fffffff, 32'sh80000000, -1));
		send_cmd(make_cmd(ACT_CLEAR, -1, -1, -1, -1, -1, -1, 31'h7fffffff, -1));
		send_cmd(make_cmd(ACT_MASS, 32'sh80000000, 32'sh7fffffff, -98304));
		send_cmd(make_cmd(ACT_UPDATE, 0, 0, 0));
		send_cmd(make_cmd(ACT_BOUNCE, 0, 0, 0));
		send_cmd(make_cmd(ACT_LOAD, -5, 32'sh7fffffff, 100 << 16, 32'sh80000000, 3, 4));
		send_cmd(make_cmd(ACT_BOUNCE, 0, 0, 0));
		send_cmd(make_cmd(ACT_LOAD, -5, 32'sh7fffffff, 100 << 16, 1, 2, 3));
		send_cmd(make_cmd(ACT_WRAP, 0, 0, 0));
		send_cmd(make_cmd(ACT_CLEAR, 0, 0, 0));
		send_cmd(make_cmd(ACT_LOAD, 10 << 16, 10 << 16, 10 << 16, 1 << 16, -(1 << 16), 0));
		send_cmd(make_cmd(ACT_REPEL, 9 << 16, 10 << 16, 10 << 16, 0, 0, 0, 0, 5 << 16));
		send_cmd(make_cmd(ACT_REPEL, 10 << 16, 10 << 16, 10 << 16, 0, 0, 0, 4 << 16, 5 << 16));
		send_cmd(make_cmd(ACT_REPEL, 9 << 16, 11 << 16, 12 << 16, 0, 0, 0, 4 << 16, 5 << 16));
		send_cmd(make_cmd(ACT_ATTRACT, 8 << 16, 10 << 16, 10 << 16, 0, 0, 0, 3 << 16, 7 << 16));
		send_cmd(make_cmd(ACT_ATTRACT, 0, 0, 0, 0, 0, 0, 31'h7fffffff, 32'sh80000000));
		send_cmd(make_cmd(ACT_REPEL, 0, 10 << 16, 10 << 16, 0, 0, 0, 3 << 16, 7 << 16));
		send_cmd(make_cmd(ACT_UPDATE, 0, 0, 0));
		send_cmd(make_cmd(ACT_UNKNOWN, -1, -1, -1, -1, -1, -1, 31'h7fffffff, -1));
		send_cmd(make_cmd(4'd9, 0, 0, 0));
		drain();
	endtask

	task automatic test_register_extremes();
		set_regs(17'd0, 25'd0, 1'b1, 31'd1);
		send_cmd(make_cmd(ACT_LOAD, -3, 2, 1, 32'sh7fffffff, -7, 9));
		send_cmd(make_cmd(ACT_MASS, 32'sh7fffffff, 32'sh80000000, 12345));
		send_cmd(make_cmd(ACT_RAW, 1 << 16, 2 << 16, -(3 << 16)));
		send_cmd(make_cmd(ACT_UPDATE, 0, 0, 0));
		send_cmd(make_cmd(ACT_BOUNCE, 0, 0, 0));
		send_cmd(make_cmd(ACT_LOAD, -3, 2, 1, 0, 0, 0));
		send_cmd(make_cmd(ACT_WRAP, 0, 0, 0));
		drain();
		set_regs(17'd65536, 25'd16777216, 1'b0, 31'h7fffffff);
		send_cmd(make_cmd(ACT_LOAD, 32'sh80000000, 32'sh7fffffff, 0,
			32'sh7fffffff, 32'sh80000000, 65536));
		send_cmd(make_cmd(ACT_MASS, 1, -1, 32'sh7fffffff));
		send_cmd(make_cmd(ACT_UPDATE, 0, 0, 0));
		send_cmd(make_cmd(ACT_BOUNCE, 0, 0, 0));
		send_cmd(make_cmd(ACT_WRAP, 0, 0, 0));
		drain();
		// Upper bits beyond each register width must be dropped.
		write_reg(REG_FRICTION, 32'hfffe_0123);
		write_reg(REG_INV_MASS, 32'hfe00_4000);
		write_reg(REG_PINNED, 32'hffff_fffe);
		write_reg(REG_WALL_MAX, 32'h8000_0000 | (500 << 16));
		send_cmd(make_cmd(ACT_MASS, 3 << 16, 0, -(1 << 16)));
		send_cmd(make_cmd(ACT_UPDATE, 0, 0, 0));
		drain();
	endtask

	task automatic test_random(int count);
		bit burst;
		for (int n = 0; n < count; n++) begin
			if (n % 50 == 0) burst = ($urandom_range(0, 3) == 0);
			send_cmd(rand_cmd(), burst);
		end
		drain();
	endtask

	task automatic test_backpressure();
		hold_req = 400;
		for (int n = 0; n < 12; n++) send_cmd(rand_cmd(), 1);
		drain();
	endtask

	always @(posedge clk) begin
		int r;
		int stall_left;
		r = $urandom_range(0, 199);
		if (hold_req > 0) begin
			stall_left = hold_req;
			hold_req = 0;
		end
		if (r == 0) rx_quiet = !rx_quiet;
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!rx_quiet && r < 16) begin
			stall_left = $urandom_range(1, 3);
			m_tready <= 1'b0;
		end else if (!rx_quiet && r == 16) begin
			stall_left = $urandom_range(20, 80);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		particle_t exp_s;
		int got;
		if (arst_n && m_tvalid && m_tready) begin
			if (state_q.size() == 0) begin
				$display("%0t: unexpected word %h", $time, m_tdata);
				errors++;
			end else begin
				exp_s = state_q.pop_front();
				for (int i = 0; i < 9; i++) begin
					got = m_tdata[32*i +: 32];
					if (got != (i < 3 ? exp_s.p[i] : i < 6 ? exp_s.v[i-3] : exp_s.f[i-6])) begin
						$display("%0t: field %0d expected %h actual %h", $time, i,
							i < 3 ? exp_s.p[i] : i < 6 ? exp_s.v[i-3] : exp_s.f[i-6], got);
						errors++;
					end
				end
				if (m_tdata[288] != exp_s.collided) begin
					$display("%0t: collided expected %0d actual %0d", $time,
						exp_s.collided, m_tdata[288]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("particle_force_integrator regression: fail");
			$finish;
		end
	end

	initial begin
		friction_gain = FRICTION_RST;
		inv_mass = INV_MASS_RST;
		pinned = 1'b0;
		wall_max = WALL_MAX_RST;
		pos = '{0, 0, 0};
		vel = '{0, 0, 0};
		frc = '{0, 0, 0};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_extremes();
		set_regs(17'd655, 25'd65536, 1'b0, 31'd131072000);
		test_random(400);
		test_backpressure();
		set_regs(17'($urandom_range(0, 65536)), 25'($urandom_range(0, 1 << 18)), 1'b0,
			31'($urandom_range(1, 32'h7fffffff)));
		test_random(300);
		set_regs(17'd65536, 25'd0, 1'b1, 31'd1);
		test_random(150);
		set_regs(17'd0, 25'd16777216, 1'b0, 31'h7fffffff);
		test_random(250);
		test_backpressure();
		set_regs(17'd3000, 25'd32768, 1'b0, 31'd1000 << 16);
		test_random(100);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("particle_force_integrator regression: pass");
		end else begin
			$display("particle_force_integrator regression: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
design/pfi_pkg.sv
design/particle_force_integrator.sv
tb/tb_top.sv
